[rtl/ll1p_pkg.sv]
// shared types, constants and codes of the ll1 predictive parser
package ll1p_pkg;

    localparam int unsigned NT_COUNT    = 32;
    localparam int unsigned T_COUNT     = 32;
    localparam int unsigned PROD_COUNT  = 64;
    localparam int unsigned RHS_MAX     = 8;
    localparam int unsigned STACK_DEPTH = 32;
    localparam int unsigned RES_MAX     = 64;

    localparam int unsigned TBL_DEPTH = NT_COUNT * T_COUNT;
    localparam int unsigned TBL_AW    = $clog2(TBL_DEPTH);
    localparam int unsigned RHS_DEPTH = PROD_COUNT * RHS_MAX;
    localparam int unsigned RHS_AW    = $clog2(RHS_DEPTH);
    localparam int unsigned SP_W      = $clog2(STACK_DEPTH) + 1;
    localparam int unsigned CNT_W     = $clog2(RES_MAX);

    localparam logic [4:0] END_RESET   = 5'd31;
    localparam logic [4:0] START_RESET = 5'd0;

    typedef enum logic [2:0] {
        MODE_TABLE  = 3'd0,
        MODE_SYMBOL = 3'd1,
        MODE_LENGTH = 3'd2,
        MODE_START  = 3'd3,
        MODE_TOKEN  = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        EV_EXPAND   = 3'd0,
        EV_MATCH    = 3'd1,
        EV_ACCEPT   = 3'd2,
        EV_MISMATCH = 3'd3,
        EV_NOENTRY  = 3'd4,
        EV_OVERFLOW = 3'd5,
        EV_STEPCAP  = 3'd6
    } t_event;

    typedef enum logic [1:0] {
        PS_IDLE   = 2'd0,
        PS_RUN    = 2'd1,
        PS_ACCEPT = 2'd2,
        PS_REJECT = 2'd3
    } t_pstat;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_TBL,
        ST_LEN,
        ST_PUSH,
        ST_EXPAND,
        ST_FINAL
    } t_state;

    typedef enum logic {
        CFG_END_MARKER = 1'b0,
        CFG_START_NT   = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [2:0] mode;
        logic [4:0] row_nonterminal;
        logic [4:0] column_terminal;
        logic       entry_valid;
        logic [5:0] production_number;
        logic [2:0] symbol_position;
        logic       symbol_is_nonterminal;
        logic [4:0] symbol_index;
        logic [3:0] production_length;
        logic [4:0] token;
    } t_in_item;

    typedef struct packed {
        logic [2:0] event_kind;
        logic [5:0] applied_production;
        logic [4:0] expanded_nonterminal;
        logic       last_of_run;
    } t_out_item;

    // commands from controller to datapath
    typedef struct packed {
        logic       clr_step;
        logic       accept;
        logic       tok_latch;
        logic       tbl_rd;
        logic       len_rd;
        logic       pop;
        logic       pop_start;
        logic       push;
        logic       emit;
        logic [2:0] emit_kind;
        logic       emit_last;
        logic       set_stat;
        t_pstat     stat;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic clr_done;
        logic run;
        logic top_empty;
        logic top_nt;
        logic top_eq_tok;
        logic tok_is_end;
        logic top_is_one;
        logic tbl_hit;
        logic ovf;
        logic cap;
        logic len_zero;
        logic cnt_one;
        logic out_free;
    } t_sts;

endpackage

[rtl/ll1p_ctrl.sv]
// controller state machine of the ll1 predictive parser
module ll1p_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [2:0]        i_mode,
    input  ll1p_pkg::t_sts    i_sts,
    output logic              o_in_ready,
    output ll1p_pkg::t_cmd    o_cmd
);

    ll1p_pkg::t_state r_state, n_state;
    logic [2:0]       r_kind, n_kind;

    // state and pending final event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ll1p_pkg::ST_CLEAR;
            r_kind  <= ll1p_pkg::EV_MISMATCH;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        unique case (r_state)
            ll1p_pkg::ST_CLEAR: begin
                if (i_sts.clr_done) n_state = ll1p_pkg::ST_IDLE;
            end
            ll1p_pkg::ST_IDLE: begin
                if (i_in_valid && i_mode == ll1p_pkg::MODE_TOKEN && i_sts.run)
                    n_state = ll1p_pkg::ST_CHECK;
            end
            ll1p_pkg::ST_CHECK: begin
                if (i_sts.top_empty) begin
                    n_kind  = ll1p_pkg::EV_MISMATCH;
                    n_state = ll1p_pkg::ST_FINAL;
                end else if (!i_sts.top_nt) begin
                    n_state = ll1p_pkg::ST_FINAL;
                    if (!i_sts.top_eq_tok)      n_kind = ll1p_pkg::EV_MISMATCH;
                    else if (!i_sts.tok_is_end) n_kind = ll1p_pkg::EV_MATCH;
                    else if (i_sts.top_is_one)  n_kind = ll1p_pkg::EV_ACCEPT;
                    else                        n_kind = ll1p_pkg::EV_MISMATCH;
                end else begin
                    n_state = ll1p_pkg::ST_TBL;
                end
            end
            ll1p_pkg::ST_TBL: begin
                if (!i_sts.tbl_hit) begin
                    n_kind  = ll1p_pkg::EV_NOENTRY;
                    n_state = ll1p_pkg::ST_FINAL;
                end else begin
                    n_state = ll1p_pkg::ST_LEN;
                end
            end
            ll1p_pkg::ST_LEN: begin
                if (i_sts.ovf) begin
                    n_kind  = ll1p_pkg::EV_OVERFLOW;
                    n_state = ll1p_pkg::ST_FINAL;
                end else if (i_sts.cap) begin
                    n_kind  = ll1p_pkg::EV_STEPCAP;
                    n_state = ll1p_pkg::ST_FINAL;
                end else if (i_sts.len_zero) begin
                    n_state = ll1p_pkg::ST_EXPAND;
                end else begin
                    n_state = ll1p_pkg::ST_PUSH;
                end
            end
            ll1p_pkg::ST_PUSH: begin
                if (i_sts.cnt_one) n_state = ll1p_pkg::ST_EXPAND;
            end
            ll1p_pkg::ST_EXPAND: begin
                if (i_sts.out_free) n_state = ll1p_pkg::ST_CHECK;
            end
            ll1p_pkg::ST_FINAL: begin
                if (i_sts.out_free) n_state = ll1p_pkg::ST_IDLE;
            end
            default: n_state = ll1p_pkg::ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.stat = ll1p_pkg::PS_REJECT;
        unique case (r_state)
            ll1p_pkg::ST_CLEAR: o_cmd.clr_step = 1'b1;
            ll1p_pkg::ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.accept    = i_in_valid;
                o_cmd.tok_latch = i_in_valid;
            end
            ll1p_pkg::ST_CHECK: begin
                o_cmd.tbl_rd = 1'b1;
                o_cmd.pop    = !i_sts.top_empty && !i_sts.top_nt && i_sts.top_eq_tok;
            end
            ll1p_pkg::ST_TBL: o_cmd.len_rd = i_sts.tbl_hit;
            ll1p_pkg::ST_LEN: o_cmd.pop_start = !i_sts.ovf && !i_sts.cap;
            ll1p_pkg::ST_PUSH: o_cmd.push = 1'b1;
            ll1p_pkg::ST_EXPAND: begin
                o_cmd.emit      = i_sts.out_free;
                o_cmd.emit_kind = ll1p_pkg::EV_EXPAND;
            end
            ll1p_pkg::ST_FINAL: begin
                o_cmd.emit      = i_sts.out_free;
                o_cmd.emit_kind = r_kind;
                o_cmd.emit_last = 1'b1;
                o_cmd.set_stat  = i_sts.out_free && r_kind != ll1p_pkg::EV_MATCH;
                o_cmd.stat      = (r_kind == ll1p_pkg::EV_ACCEPT) ? ll1p_pkg::PS_ACCEPT
                                                                  : ll1p_pkg::PS_REJECT;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

endmodule

[rtl/ll1p_dpath.sv]
// datapath of the ll1 predictive parser: tables, stack and result register
module ll1p_dpath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ll1p_pkg::t_in_item  i_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [4:0]          i_cfg_data,
    input  ll1p_pkg::t_cmd      i_cmd,
    input  logic                i_out_ready,
    output ll1p_pkg::t_sts      o_sts,
    output logic                o_out_valid,
    output ll1p_pkg::t_out_item o_out_item
);

    localparam logic [6:0] OVF_LIMIT = 7'(ll1p_pkg::STACK_DEPTH + 1);
    localparam logic [3:0] LEN_SAT   = 4'(ll1p_pkg::RHS_MAX);

    logic [6:0] r_table [ll1p_pkg::TBL_DEPTH];
    logic [5:0] r_rhs   [ll1p_pkg::RHS_DEPTH];
    logic [3:0] r_lens  [ll1p_pkg::PROD_COUNT];
    logic [5:0] r_stack [ll1p_pkg::STACK_DEPTH];

    logic [ll1p_pkg::TBL_AW:0]     r_clr_addr;
    logic [6:0]                    r_tbl_q;
    logic [5:0]                    r_rhs_q;
    logic [3:0]                    r_len_q;
    logic [ll1p_pkg::SP_W-1:0]     r_top;
    logic [3:0]                    r_cnt;
    logic [ll1p_pkg::CNT_W-1:0]    r_n;
    logic [5:0]                    r_prod;
    logic [4:0]                    r_nt;
    logic [4:0]                    r_tok;
    logic [4:0]                    r_end;
    logic [4:0]                    r_start;
    ll1p_pkg::t_pstat              r_pstat;
    logic                          r_out_valid;
    ll1p_pkg::t_out_item           r_out;

    logic [ll1p_pkg::SP_W-1:0]     top_m1;
    logic [5:0]                    top_sym;
    logic                          tbl_we;
    logic [ll1p_pkg::TBL_AW-1:0]   tbl_waddr;
    logic [6:0]                    tbl_wdata;
    logic [ll1p_pkg::RHS_AW-1:0]   rhs_raddr;
    logic [2:0]                    rhs_pos;
    logic [3:0]                    len_wdata;
    logic                          ld_table, ld_symbol, ld_length, ld_start;

    assign top_m1  = r_top - 1'b1;
    assign top_sym = r_stack[top_m1[ll1p_pkg::SP_W-2:0]];

    // load decode
    always_comb begin
        ld_table  = 1'b0;
        ld_symbol = 1'b0;
        ld_length = 1'b0;
        ld_start  = 1'b0;
        unique case (i_item.mode)
            ll1p_pkg::MODE_TABLE:  ld_table  = i_cmd.accept;
            ll1p_pkg::MODE_SYMBOL: ld_symbol = i_cmd.accept;
            ll1p_pkg::MODE_LENGTH: ld_length = i_cmd.accept;
            ll1p_pkg::MODE_START:  ld_start  = i_cmd.accept;
            default:               ld_start  = 1'b0;
        endcase
    end

    // table write port: clearing pass or cell load
    always_comb begin
        tbl_we    = i_cmd.clr_step || ld_table;
        tbl_waddr = i_cmd.clr_step ? r_clr_addr[ll1p_pkg::TBL_AW-1:0]
                                   : {i_item.row_nonterminal, i_item.column_terminal};
        tbl_wdata = (!i_cmd.clr_step && i_item.entry_valid)
                  ? {1'b1, i_item.production_number} : 7'd0;
    end

    // parse table memory
    always_ff @(posedge i_clk) begin
        if (tbl_we) r_table[tbl_waddr] <= tbl_wdata;
        if (i_cmd.tbl_rd) r_tbl_q <= r_table[{top_sym[4:0], r_tok}];
    end

    // rhs symbol memory
    assign rhs_pos   = i_cmd.pop_start ? 3'(r_len_q - 4'd1) : 3'(r_cnt - 4'd2);
    assign rhs_raddr = {r_prod, rhs_pos};
    always_ff @(posedge i_clk) begin
        if (ld_symbol)
            r_rhs[{i_item.production_number, i_item.symbol_position}] <=
                {i_item.symbol_is_nonterminal, i_item.symbol_index};
        if (i_cmd.pop_start || i_cmd.push) r_rhs_q <= r_rhs[rhs_raddr];
    end

    // rhs length memory, saturated on write
    assign len_wdata = (i_item.production_length > LEN_SAT) ? LEN_SAT
                                                            : i_item.production_length;
    always_ff @(posedge i_clk) begin
        if (ld_length) r_lens[i_item.production_number] <= len_wdata;
        if (i_cmd.len_rd) r_len_q <= r_lens[r_tbl_q[5:0]];
    end

    // expansion payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.len_rd) begin
            r_prod <= r_tbl_q[5:0];
            r_nt   <= top_sym[4:0];
        end
        if (i_cmd.tok_latch) r_tok <= i_item.token;
    end

    // stack contents
    always_ff @(posedge i_clk) begin
        if (ld_start) begin
            r_stack[0] <= {1'b0, r_end};
            r_stack[1] <= {1'b1, r_start};
        end else if (i_cmd.push) begin
            r_stack[r_top[ll1p_pkg::SP_W-2:0]] <= r_rhs_q;
        end
    end

    // stack pointer, push count, result count, clear sweep, status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top      <= '0;
            r_cnt      <= '0;
            r_n        <= '0;
            r_clr_addr <= '0;
            r_pstat    <= ll1p_pkg::PS_IDLE;
        end else begin
            if (i_cmd.clr_step) r_clr_addr <= r_clr_addr + 1'b1;
            if (ld_start) begin
                r_top   <= ll1p_pkg::SP_W'(2);
                r_pstat <= ll1p_pkg::PS_RUN;
            end else if (i_cmd.pop || i_cmd.pop_start) begin
                r_top <= top_m1;
            end else if (i_cmd.push) begin
                r_top <= r_top + 1'b1;
            end
            if (i_cmd.pop_start) r_cnt <= r_len_q;
            else if (i_cmd.push) r_cnt <= r_cnt - 4'd1;
            if (i_cmd.tok_latch) r_n <= '0;
            else if (i_cmd.emit) r_n <= r_n + 1'b1;
            if (i_cmd.set_stat) r_pstat <= i_cmd.stat;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end   <= ll1p_pkg::END_RESET;
            r_start <= ll1p_pkg::START_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == ll1p_pkg::CFG_END_MARKER) r_end   <= i_cfg_data;
            else                                         r_start <= i_cfg_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.event_kind  <= i_cmd.emit_kind;
            r_out.last_of_run <= i_cmd.emit_last;
            if (i_cmd.emit_kind == ll1p_pkg::EV_EXPAND) begin
                r_out.applied_production   <= r_prod;
                r_out.expanded_nonterminal <= r_nt;
            end else begin
                r_out.applied_production   <= 6'd0;
                r_out.expanded_nonterminal <= 5'd0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // status toward the controller
    always_comb begin
        o_sts.clr_done   = r_clr_addr[ll1p_pkg::TBL_AW];
        o_sts.run        = (r_pstat == ll1p_pkg::PS_RUN);
        o_sts.top_empty  = (r_top == '0);
        o_sts.top_nt     = top_sym[5];
        o_sts.top_eq_tok = (top_sym[4:0] == r_tok);
        o_sts.tok_is_end = (r_tok == r_end);
        o_sts.top_is_one = (r_top == ll1p_pkg::SP_W'(1));
        o_sts.tbl_hit    = r_tbl_q[6];
        o_sts.ovf        = (7'(r_top) + 7'(r_len_q)) > OVF_LIMIT;
        o_sts.cap        = (r_n == ll1p_pkg::CNT_W'(ll1p_pkg::RES_MAX - 1));
        o_sts.len_zero   = (r_len_q == 4'd0);
        o_sts.cnt_one    = (r_cnt == 4'd1);
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

endmodule

[rtl/ll1_predictive_parser.sv]
// top level of the table-driven ll1 predictive parser
// After reset the parser sweeps its 1024-cell parse table to empty, one cell a
// cycle, and holds o_in_ready low until it sees the sweep done; configuration
// writes are taken throughout. Table, symbol, length and start requests are
// taken in the idle state and leave the parser idle. A token request with a
// terminal on top of the stack passes through accept, check and report, and
// each expansion before that adds a parse-table read, a length read, one stack
// push per right-hand-side symbol from the single-port symbol memory, then the
// expand report. A result waits in a one-entry output register, so a stalled
// consumer holds the parser only when the next result is ready.
module ll1_predictive_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ll1p_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ll1p_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [4:0]          i_cfg_data
);

    ll1p_pkg::t_cmd cmd;
    ll1p_pkg::t_sts sts;

    // sequencer
    ll1p_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_in_item.mode),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // storage and result register
    ll1p_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

[rtl/ll1p_checker.sv]
// port-level assertions of the ll1 predictive parser and their bind
module ll1p_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input ll1p_pkg::t_out_item o_out_item
);

    // table clearing keeps requests out right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("request taken during table clear");

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // expand events never close a run
    a_expand_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.event_kind == ll1p_pkg::EV_EXPAND
        |-> !o_out_item.last_of_run)
        else $error("expand flagged as last");

    // every other event closes the run and carries no production
    a_final_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.event_kind != ll1p_pkg::EV_EXPAND
        |-> o_out_item.last_of_run && o_out_item.applied_production == 6'd0
            && o_out_item.expanded_nonterminal == 5'd0)
        else $error("final event fields wrong");

endmodule

bind ll1_predictive_parser ll1p_checker u_ll1p_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

[dv/ll1_predictive_parser_tb.sv]
// self-checking testbench of the ll1 predictive parser: directed and random grammars and tokens
module ll1_predictive_parser_tb;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    ll1p_pkg::t_in_item  i_in_item;
    logic                o_out_valid;
    logic                i_out_ready;
    ll1p_pkg::t_out_item o_out_item;
    logic                i_cfg_we;
    logic                i_cfg_index;
    logic [4:0]          i_cfg_data;

    ll1_predictive_parser uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_item(o_out_item),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic [4:0]       end_term;
    logic [4:0]       start_nt;
    logic [6:0]       table_mem [0:1023];
    logic [5:0]       rhs_mem [0:511];
    logic [3:0]       len_mem [0:63];
    logic [5:0]       stk [0:31];
    int               depth;
    ll1p_pkg::t_pstat pstat;

    ll1p_pkg::t_in_item  pending_q [$];
    ll1p_pkg::t_out_item events_q [$];
    int        errors;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        hold_cycles;
    bit        hold_req;

    initial begin
        i_clk = 1'b0;
    end
    always #10 i_clk = ~i_clk;

    function automatic ll1p_pkg::t_out_item mk(ll1p_pkg::t_event k, logic [5:0] p,
                                               logic [4:0] n, logic l);
        ll1p_pkg::t_out_item o;
        o.event_kind = k;
        o.applied_production = p;
        o.expanded_nonterminal = n;
        o.last_of_run = l;
        return o;
    endfunction

    // append to the expected result queue
    task automatic exp_add(input ll1p_pkg::t_out_item ev);
        events_q = {events_q, ev};
    endtask

    // append to the pending request queue
    task automatic pend_add(input ll1p_pkg::t_in_item it);
        pending_q = {pending_q, it};
    endtask

    // work out the events that one parse token causes
    task automatic parse_token(input logic [4:0] tok);
        int         n;
        logic [5:0] top;
        logic [6:0] tbl_entry;
        int         len;
        n = 0;
        forever begin
            if (depth == 0) begin
                exp_add(mk(ll1p_pkg::EV_MISMATCH, 6'd0, 5'd0, 1'b1));
                pstat = ll1p_pkg::PS_REJECT;
                return;
            end
            top = stk[depth-1];
            if (!top[5]) begin
                if (top[4:0] != tok) begin
                    exp_add(mk(ll1p_pkg::EV_MISMATCH, 6'd0, 5'd0, 1'b1));
                    pstat = ll1p_pkg::PS_REJECT;
                    return;
                end
                depth--;
                if (tok == end_term) begin
                    if (depth == 0) begin
                        exp_add(mk(ll1p_pkg::EV_ACCEPT, 6'd0, 5'd0, 1'b1));
                        pstat = ll1p_pkg::PS_ACCEPT;
                    end else begin
                        exp_add(mk(ll1p_pkg::EV_MISMATCH, 6'd0, 5'd0, 1'b1));
                        pstat = ll1p_pkg::PS_REJECT;
                    end
                    return;
                end
                exp_add(mk(ll1p_pkg::EV_MATCH, 6'd0, 5'd0, 1'b1));
                return;
            end
            tbl_entry = table_mem[{top[4:0], tok}];
            if (!tbl_entry[6]) begin
                exp_add(mk(ll1p_pkg::EV_NOENTRY, 6'd0, 5'd0, 1'b1));
                pstat = ll1p_pkg::PS_REJECT;
                return;
            end
            len = len_mem[tbl_entry[5:0]];
            if (depth - 1 + len > 32) begin
                exp_add(mk(ll1p_pkg::EV_OVERFLOW, 6'd0, 5'd0, 1'b1));
                pstat = ll1p_pkg::PS_REJECT;
                return;
            end
            if (n >= 63) begin
                exp_add(mk(ll1p_pkg::EV_STEPCAP, 6'd0, 5'd0, 1'b1));
                pstat = ll1p_pkg::PS_REJECT;
                return;
            end
            depth--;
            for (int i = len; i > 0; i--) begin
                stk[depth] = rhs_mem[{tbl_entry[5:0], 3'(i-1)}];
                depth++;
            end
            exp_add(mk(ll1p_pkg::EV_EXPAND, tbl_entry[5:0], top[4:0], 1'b0));
            n++;
        end
    endtask

    task automatic predict(input ll1p_pkg::t_in_item it);
        case (it.mode)
            ll1p_pkg::MODE_TABLE: table_mem[{it.row_nonterminal, it.column_terminal}] =
                it.entry_valid ? {1'b1, it.production_number} : 7'd0;
            ll1p_pkg::MODE_SYMBOL: rhs_mem[{it.production_number, it.symbol_position}] =
                {it.symbol_is_nonterminal, it.symbol_index};
            ll1p_pkg::MODE_LENGTH: len_mem[it.production_number] =
                it.production_length > 4'd8 ? 4'd8 : it.production_length;
            ll1p_pkg::MODE_START: begin
                stk[0] = {1'b0, end_term};
                stk[1] = {1'b1, start_nt};
                depth = 2;
                pstat = ll1p_pkg::PS_RUN;
            end
            ll1p_pkg::MODE_TOKEN: if (pstat == ll1p_pkg::PS_RUN) parse_token(it.token);
            default: ;
        endcase
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_item <= pending_q[0];
                predict(pending_q.pop_front());
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stalls, with a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_cycles <= 0;
        end else if (hold_req && hold_cycles < 300) begin
            hold_cycles <= hold_cycles + 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        ll1p_pkg::t_out_item exp_ev;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (events_q.size() == 0) begin
                $error("unexpected result %p", o_out_item);
                errors++;
            end else begin
                exp_ev = events_q.pop_front();
                if (o_out_item.event_kind != exp_ev.event_kind) begin
                    $error("event_kind exp %0d got %0d", exp_ev.event_kind,
                           o_out_item.event_kind);
                    errors++;
                end
                if (o_out_item.applied_production != exp_ev.applied_production) begin
                    $error("applied_production exp %0d got %0d",
                           exp_ev.applied_production, o_out_item.applied_production);
                    errors++;
                end
                if (o_out_item.expanded_nonterminal != exp_ev.expanded_nonterminal) begin
                    $error("expanded_nonterminal exp %0d got %0d",
                           exp_ev.expanded_nonterminal, o_out_item.expanded_nonterminal);
                    errors++;
                end
                if (o_out_item.last_of_run != exp_ev.last_of_run) begin
                    $error("last_of_run exp %0d got %0d", exp_ev.last_of_run,
                           o_out_item.last_of_run);
                    errors++;
                end
            end
        end
    end

    function automatic ll1p_pkg::t_in_item blank(ll1p_pkg::t_mode m);
        ll1p_pkg::t_in_item it;
        it = ll1p_pkg::t_in_item'($urandom());
        it.mode = m;
        return it;
    endfunction

    task automatic q_cell(int r, int c, bit v, int p);
        ll1p_pkg::t_in_item it;
        it = blank(ll1p_pkg::MODE_TABLE);
        it.row_nonterminal = 5'(r);
        it.column_terminal = 5'(c);
        it.entry_valid = v;
        it.production_number = 6'(p);
        pend_add(it);
    endtask

    task automatic q_sym(int p, int pos, bit nt, int s);
        ll1p_pkg::t_in_item it;
        it = blank(ll1p_pkg::MODE_SYMBOL);
        it.production_number = 6'(p);
        it.symbol_position = 3'(pos);
        it.symbol_is_nonterminal = nt;
        it.symbol_index = 5'(s);
        pend_add(it);
    endtask

    // write a full production so no unwritten symbol is ever read
    task automatic q_prod(int p, int l, int syms[8], bit nts[8]);
        ll1p_pkg::t_in_item it;
        for (int i = 0; i < 8; i++) q_sym(p, i, nts[i], syms[i]);
        it = blank(ll1p_pkg::MODE_LENGTH);
        it.production_number = 6'(p);
        it.production_length = 4'(l);
        pend_add(it);
    endtask

    task automatic q_start();
        pend_add(blank(ll1p_pkg::MODE_START));
    endtask

    task automatic q_tok(int t);
        ll1p_pkg::t_in_item it;
        it = blank(ll1p_pkg::MODE_TOKEN);
        it.token = 5'(t);
        pend_add(it);
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || events_q.size() > 0 || i_in_valid)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_cfg(ll1p_pkg::t_cfg_reg idx, logic [4:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == ll1p_pkg::CFG_END_MARKER) end_term = val;
        else start_nt = val;
    endtask

    // grammar: S(start)->a S b | empty (taken on b or e) ; end marker e fixed by config
    task automatic build_grammar(int s, int a, int b, int e);
        int  syms[8];
        bit  nts[8];
        for (int i = 0; i < 8; i++) begin
            syms[i] = $urandom_range(31);
            nts[i] = 1'($urandom_range(1));
        end
        syms[0] = a; nts[0] = 0;
        syms[1] = s; nts[1] = 1;
        syms[2] = b; nts[2] = 0;
        q_prod(1, 3, syms, nts);
        q_prod(2, 0, syms, nts);
        q_cell(s, a, 1, 1);
        q_cell(s, b, 1, 2);
        q_cell(s, e, 1, 2);
    endtask

    initial begin
        int  syms[8];
        bit  nts[8];
        int  s, a, b, e, k, count;
        errors = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = ll1p_pkg::CFG_END_MARKER;
        i_cfg_data = 5'd0;
        end_term = ll1p_pkg::END_RESET;
        start_nt = ll1p_pkg::START_RESET;
        depth = 0;
        pstat = ll1p_pkg::PS_IDLE;
        for (int i = 0; i < 1024; i++) table_mem[i] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle token, unknown modes, reset config grammar
        q_tok(31);
        pend_add(blank(ll1p_pkg::t_mode'(3'd5)));
        pend_add(blank(ll1p_pkg::t_mode'(3'd7)));
        build_grammar(0, 0, 1, 31);
        q_start(); q_tok(0); q_tok(0); q_tok(1); q_tok(1); q_tok(31);
        q_tok(0);                       // ignored after accept
        q_start(); q_tok(5);            // no entry
        q_start(); q_tok(0); q_tok(31); // mismatch
        drain();

        // extremes of config, overflow and step cap
        write_cfg(ll1p_pkg::CFG_END_MARKER, 5'd0);
        write_cfg(ll1p_pkg::CFG_START_NT, 5'd31);
        for (int i = 0; i < 8; i++) begin syms[i] = 31; nts[i] = 1; end
        q_prod(63, 15, syms, nts);      // length saturates to 8, S->S^8
        q_cell(31, 7, 1, 63);
        q_start(); q_tok(7);            // overflow
        syms[0] = 31; nts[0] = 1;
        q_prod(5, 1, syms, nts);        // S->S forever: step cap
        q_cell(31, 9, 1, 5);
        q_start(); q_tok(9);
        q_cell(31, 9, 0, 5);
        q_start(); q_tok(9);            // cleared cell
        drain();

        // random phases
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 46 : 38) : 0;
            recv_idle_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 46 : 38) : 0;
            s = $urandom_range(31); e = $urandom_range(31);
            do a = $urandom_range(31); while (a == e);
            do b = $urandom_range(31); while (b == e || b == a);
            write_cfg(ll1p_pkg::CFG_END_MARKER, e[4:0]);
            write_cfg(ll1p_pkg::CFG_START_NT, s[4:0]);
            build_grammar(s, a, b, e);
            if (ph == 0) hold_req = 1'b1;
            count = 0;
            while (count < 60) begin
                q_start();
                k = $urandom_range(12);
                if ($urandom_range(9) < 7) begin
                    for (int i = 0; i < k; i++) q_tok(a);
                    for (int i = 0; i < k; i++) q_tok(b);
                    q_tok(e);
                    count += 2 * k + 1;
                end else begin
                    for (int i = 0; i < k + 1; i++) q_tok($urandom_range(31));
                    count += k + 1;
                end
                if ($urandom_range(9) == 0) begin
                    q_cell($urandom_range(31), $urandom_range(31), 0, $urandom_range(63));
                    q_cell(s, a, 1, 1);
                end
            end
            drain();
        end

        if (errors == 0) $display("ll1_predictive_parser_tb: PASS");
        else $display("ll1_predictive_parser_tb: FAIL");
        $finish;
    end

    initial begin
        #20000000;
        $display("ll1_predictive_parser_tb: FAIL");
        $finish;
    end

endmodule

[sim.f]
rtl/ll1p_pkg.sv
rtl/ll1p_ctrl.sv
rtl/ll1p_dpath.sv
rtl/ll1_predictive_parser.sv
rtl/ll1p_checker.sv
dv/ll1_predictive_parser_tb.sv
